// File: src/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define DQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deque check failed");

// Consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: src/dq_pkg.sv
// Types, constants and helper functions of the double-ended queue.
package dq_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * DATA_WIDTH + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  // Result information passed from the controller to the output stage.
  typedef struct packed {
    logic                 load;
    status_t              status;
    logic [CNT_W-1:0]     count;
    logic                 empty;
  } res_t;

  // Reduce a sum below twice the depth into a buffer position.
  function automatic logic [ADDR_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return r[ADDR_W-1:0];
  endfunction

endpackage

// File: src/dq_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module dq_ram #(
  parameter  int DEPTH = 16,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: src/dq_ctrl.sv
// Pointer, count and sequencing logic of the double-ended queue.
`include "double_ended_queue_defines.svh"

module dq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dq_pkg::OP_W-1:0]        op,
  input  logic [dq_pkg::DATA_WIDTH-1:0]  value,
  input  logic                           out_free,
  output logic                           ram_we,
  output logic [dq_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [dq_pkg::DATA_WIDTH-1:0]  ram_wdata,
  output logic                           ram_re,
  output logic [dq_pkg::ADDR_W-1:0]      ram_raddr_front,
  output logic [dq_pkg::ADDR_W-1:0]      ram_raddr_back,
  output dq_pkg::res_t                   res
);

  import dq_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] front_index;
  logic [ADDR_W-1:0] front_index_next;
  logic [CNT_W-1:0]  stored_count;
  logic [CNT_W-1:0]  stored_count_next;
  status_t           status;
  status_t           status_next;
  logic              accept;
  logic              full;
  logic              empty;
  logic [ADDR_W-1:0] front_dec;
  logic [ADDR_W-1:0] front_inc;
  logic [ADDR_W-1:0] back_pos;

  assign accept = in_valid && in_ready;
  assign full   = (stored_count == CNT_W'(DEPTH));
  assign empty  = (stored_count == '0);

  // Neighbor positions of the front entry, wrapping around the buffer.
  assign front_dec = (front_index == '0) ? ADDR_W'(DEPTH - 1) : front_index - 1'b1;
  assign front_inc = (front_index == ADDR_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;

  // Operation decode: pointer and count update, status and the entry write of a push.
  always_comb begin
    front_index_next  = front_index;
    stored_count_next = stored_count;
    status_next       = ST_OK;
    ram_we            = 1'b0;
    ram_waddr         = front_index;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          front_index_next  = front_dec;
          ram_we            = accept;
          ram_waddr         = front_dec;
          stored_count_next = stored_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ram_we            = accept;
          ram_waddr         = wrap_pos(SUM_W'(front_index) + SUM_W'(stored_count));
          stored_count_next = stored_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          front_index_next  = front_inc;
          stored_count_next = stored_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          stored_count_next = stored_count - 1'b1;
        end
      end
      OP_CLEAR: begin
        front_index_next  = '0;
        stored_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = value;

  // Queue state registers, updated on an accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= '0;
      stored_count <= '0;
      status       <= ST_OK;
    end else if (accept) begin
      front_index  <= front_index_next;
      stored_count <= stored_count_next;
      status       <= status_next;
    end
  end

  // Back entry position; an empty queue reads a don't-care entry.
  assign back_pos = wrap_pos(SUM_W'(front_index) + SUM_W'(stored_count) - SUM_W'(1));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready        = 1'b0;
    ram_re          = 1'b0;
    res.load        = 1'b0;
    res.status      = status;
    res.count       = stored_count;
    res.empty       = empty;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_RESP: begin
        res.load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign ram_raddr_front = front_index;
  assign ram_raddr_back  = back_pos;

  // The count never passes the buffer depth.
  `DQ_ASSERT_ALWAYS(a_count_bound, stored_count <= CNT_W'(DEPTH))
  // An entry is written only in the cycle of an accepted transfer.
  `DQ_ASSERT_IMP(a_write_on_accept, ram_we, accept)
  // An accepted transfer is followed by the read of its front and back.
  `DQ_ASSERT_NXT(a_accept_then_read, accept, ram_re && !in_ready)
  // A result is loaded only after the entries were read.
  `DQ_ASSERT_IMP(a_load_after_read, res.load, state == S_RESP && out_free)
  // A push that is not an overflow grows the queue by one entry.
  `DQ_ASSERT_NXT(a_push_grows, accept && !full &&
                 (op == OP_PUSH_FRONT || op == OP_PUSH_BACK),
                 stored_count == $past(stored_count) + 1'b1)

endmodule

// File: src/double_ended_queue.sv
// Top level of the double-ended queue: memory, controller and result register.
//
// Usage:
//   Input channel s_*: one transfer carries one operation. s_tuser holds the
//   operation code (push front, push back, pop front, pop back, clear) and
//   s_tdata the value that a push stores.
//   Output channel m_*: every operation gives exactly one result with the
//   front and back entries, the entry count and the empty flag in m_tdata
//   and the status (ok, underflow, overflow) in m_tuser.
//   Sequence: the operation updates the pointers and writes the entry, then the
//   memory is read at the new front and back positions and the result is
//   loaded into the result register; an operation is taken only in the idle
//   state, so no new operation is taken before the last one has finished.
//   Stall: the result register holds a result while m_tready is low; the next
//   operation is not taken until the waiting result has been loaded.
//   Reset: the queue is empty with the front at position zero; the entries
//   are not cleared and no result is pending.
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: value
  input  logic [dq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // s_tuser: op
  input  logic [dq_pkg::OP_W-1:0]         s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: front_value, back_value, entry_count, is_empty
  output logic [dq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // m_tuser: status
  output logic [dq_pkg::STATUS_W-1:0]     m_tuser
);

  import dq_pkg::*;

  logic                  out_free;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr_front;
  logic [ADDR_W-1:0]     ram_raddr_back;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] back_data;
  res_t                  res;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;

  assign out_free = !m_tvalid || m_tready;

  dq_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .op              (s_tuser),
    .value           (s_tdata[DATA_WIDTH-1:0]),
    .out_free        (out_free),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr_front (ram_raddr_front),
    .ram_raddr_back  (ram_raddr_back),
    .res             (res)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_front),
    .raddr_b (ram_raddr_back),
    .rdata_a (front_data),
    .rdata_b (back_data)
  );

  // An empty queue reports zero for both ends.
  assign front_value = res.empty ? '0 : front_data;
  assign back_value  = res.empty ? '0 : back_data;

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tdata <= OUT_TDATA_W'({res.empty, res.count, back_value, front_value});
      m_tuser <= res.status;
    end
  end

endmodule
